### design/ppqh_pkg.sv
// shared constants and helpers for the per-position quality histogram
package ppqh_pkg;

    localparam int POSITIONS_DEF      = 256;
    localparam int QUALITY_LEVELS_DEF = 128;
    localparam int PERCENT_SCALE      = 100;

    // accumulator widths: 128 bins of 32 bits times up to 127 (sum), or times 100 (rank run)
    localparam int QSUM_W  = 48;
    localparam int ABOVE_W = 40;
    localparam int RUN_W   = 48;
    localparam int THR_W   = 39;

    localparam logic [6:0] OFFSET_RESET = 7'd33;

    // item kinds carried in s_tuser
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register map
    localparam int         PADDR_W             = 3;
    localparam logic [0:0] REG_QUALITY_OFFSET  = 1'b0;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

### design/per_position_quality_histogram_top.sv
// per-position quality histogram with percentile report
// adds: one transfer per cycle while idle, read-modify-write with forwarding
// reports: one bin read per cycle
//   from the bin memory; next item accepted after the result is loaded
// clear items and reset: a clearing pass over POSITIONS*QUALITY_LEVELS bins (32768 by default)
//   during which no item is accepted; reset also sets the offset register to 33
module per_position_quality_histogram_top
    import ppqh_pkg::*;
#(
    parameter int POSITIONS      = POSITIONS_DEF,
    parameter int QUALITY_LEVELS = QUALITY_LEVELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,    // position, quality_char, percent_rank
    input  logic [1:0]          s_tuser,    // op
    output logic                m_tvalid,
    input  logic                m_tready,
    // lowest_quality, highest_quality, total_count, quality_sum, count_above_offset,
    // percentile_value
    output logic [151:0]        m_tdata,
    output logic [0:0]          m_tuser,    // empty_res
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int PW    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int IW    = $clog2(QUALITY_LEVELS);
    localparam int DEPTH = POSITIONS * QUALITY_LEVELS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_THRESH,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // memories
    logic [31:0] bin_mem [DEPTH];
    logic [31:0] tot_mem [POSITIONS];
    logic [31:0] bin_rdata_reg;
    logic [31:0] tot_rdata_reg;
    logic [AW-1:0] bin_raddr, bin_waddr;
    logic [PW-1:0] tot_raddr, tot_waddr;
    logic [31:0] bin_wdata, tot_wdata;
    logic        bin_we, tot_we;

    // control
    logic [AW:0]   clr_cnt_reg;
    logic          a1_valid_reg;
    logic          fwd_valid_reg;
    logic [IW:0]   rd_idx_reg;
    logic          proc_valid_reg;
    logic          seen_reg;
    logic          found_reg;
    logic          out_valid_reg;
    logic [6:0]    offset_reg;

    // payload
    logic [AW-1:0]      a1_baddr_reg, fwd_baddr_reg, rpt_base_reg;
    logic [PW-1:0]      a1_pidx_reg, fwd_pidx_reg, rpt_pidx_reg;
    logic [31:0]        fwd_bval_reg, fwd_tval_reg;
    logic               rpt_valid_reg;
    logic [6:0]         rpt_rank_reg;
    logic [31:0]        total_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [IW-1:0]      proc_idx_reg;
    logic [IW-1:0]      lo_reg, hi_reg;
    logic [QSUM_W-1:0]  qsum_reg;
    logic [ABOVE_W-1:0] above_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [7:0]         pct_reg;

    logic               out_empty_reg;
    logic [6:0]         out_lo_reg, out_hi_reg;
    logic [31:0]        out_total_reg, out_above_reg;
    logic [QSUM_W-1:0]  out_qsum_reg;
    logic [7:0]         out_pct_reg;

    // input unpack
    logic [1:0]    in_op;
    logic [7:0]    in_pos;
    logic [6:0]    in_qc, in_rank;
    logic          in_acc, pos_ok, qc_ok;
    logic [PW-1:0] in_pidx;
    logic [AW-1:0] in_base, in_baddr;

    assign in_op   = s_tuser;
    assign in_pos  = s_tdata[7:0];
    assign in_qc   = s_tdata[14:8];
    assign in_rank = s_tdata[21:15];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign pos_ok   = 32'(in_pos) < 32'(POSITIONS);
    assign qc_ok    = 32'(in_qc) < 32'(QUALITY_LEVELS);
    assign in_pidx  = PW'(in_pos);
    assign in_base  = AW'(in_pidx) * AW'(QUALITY_LEVELS);
    assign in_baddr = in_base + AW'(in_qc);

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[PADDR_W-1:2] == REG_QUALITY_OFFSET);
    assign prdata = (paddr[PADDR_W-1:2] == REG_QUALITY_OFFSET) ? 32'(offset_reg) : 32'd0;

    // add stage: forward the value written in the previous cycle on an address match
    logic [31:0] bin_old, tot_old;
    assign bin_old = (fwd_valid_reg && fwd_baddr_reg == a1_baddr_reg) ? fwd_bval_reg
                                                                      : bin_rdata_reg;
    assign tot_old = (fwd_valid_reg && fwd_pidx_reg == a1_pidx_reg) ? fwd_tval_reg
                                                                    : tot_rdata_reg;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            bin_we    = 1'b1;
            bin_waddr = clr_cnt_reg[AW-1:0];
            bin_wdata = 32'd0;
            tot_we    = clr_cnt_reg < (AW+1)'(POSITIONS);
            tot_waddr = clr_cnt_reg[PW-1:0];
            tot_wdata = 32'd0;
        end
        else
        begin
            bin_we    = a1_valid_reg;
            bin_waddr = a1_baddr_reg;
            bin_wdata = sat_inc(bin_old);
            tot_we    = a1_valid_reg;
            tot_waddr = a1_pidx_reg;
            tot_wdata = sat_inc(tot_old);
        end
    end

    assign bin_raddr = (state_reg == ST_SCAN) ? rpt_base_reg + AW'(rd_idx_reg[IW-1:0])
                                              : in_baddr;
    assign tot_raddr = (state_reg == ST_IDLE) ? in_pidx : rpt_pidx_reg;

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        bin_rdata_reg <= bin_mem[bin_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tot_we)
        begin
            tot_mem[tot_waddr] <= tot_wdata;
        end
        tot_rdata_reg <= tot_mem[tot_raddr];
    end

    // scan datapath
    logic [31:0]        bin_c, tot_val;
    logic               at_off, hit;
    logic [8:0]         rel_diff;
    logic [7:0]         rel;
    logic [39:0]        prod;
    logic [QSUM_W-1:0]  qsum_next;
    logic [ABOVE_W-1:0] above_next;
    logic [RUN_W-1:0]   run_next;
    logic               out_load;

    assign bin_c      = rpt_valid_reg ? bin_rdata_reg : 32'd0;
    assign tot_val    = rpt_valid_reg ? tot_rdata_reg : 32'd0;
    assign at_off     = 9'(proc_idx_reg) >= 9'(offset_reg);
    assign rel_diff   = 9'(proc_idx_reg) - 9'(offset_reg);
    assign rel        = rel_diff[7:0];
    assign prod       = 40'(bin_c) * 40'(rel);
    assign qsum_next  = qsum_reg + QSUM_W'(prod);
    assign above_next = above_reg + ABOVE_W'(bin_c);
    // run >= floor(total*rank/100) checked as 100*(run+1) > total*rank
    assign run_next   = run_reg + RUN_W'(39'(bin_c) * 39'(PERCENT_SCALE));
    assign hit        = (run_next + RUN_W'(PERCENT_SCALE)) > RUN_W'(thr_reg);
    assign out_load   = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            a1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            rd_idx_reg     <= '0;
            proc_valid_reg <= 1'b0;
            seen_reg       <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            offset_reg     <= OFFSET_RESET;
        end
        else
        begin
            if (cfg_wr)
            begin
                offset_reg <= pwdata[6:0];
            end
            a1_valid_reg  <= in_acc && (in_op == OP_ADD) && pos_ok && qc_ok;
            fwd_valid_reg <= a1_valid_reg;

            if (proc_valid_reg)
            begin
                if (bin_c != 32'd0)
                begin
                    seen_reg <= 1'b1;
                end
                if (at_off && hit)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == (AW+1)'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (in_op)
                            OP_REPORT: state_reg <= ST_LOAD;
                            OP_CLEAR:
                            begin
                                state_reg   <= ST_CLEAR;
                                clr_cnt_reg <= '0;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_THRESH;
                end
                ST_THRESH:
                begin
                    rd_idx_reg     <= '0;
                    proc_valid_reg <= 1'b0;
                    seen_reg       <= 1'b0;
                    found_reg      <= 1'b0;
                    state_reg      <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (rd_idx_reg < (IW+1)'(QUALITY_LEVELS))
                    begin
                        rd_idx_reg     <= rd_idx_reg + 1'b1;
                        proc_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        // last bin is processed in this cycle
                        proc_valid_reg <= 1'b0;
                        state_reg      <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a1_baddr_reg  <= in_baddr;
            a1_pidx_reg   <= in_pidx;
            rpt_base_reg  <= in_base;
            rpt_pidx_reg  <= in_pidx;
            rpt_valid_reg <= pos_ok;
            rpt_rank_reg  <= in_rank;
        end
        fwd_baddr_reg <= a1_baddr_reg;
        fwd_pidx_reg  <= a1_pidx_reg;
        fwd_bval_reg  <= bin_wdata;
        fwd_tval_reg  <= tot_wdata;

        if (state_reg == ST_THRESH)
        begin
            total_reg <= tot_val;
            thr_reg   <= THR_W'(tot_val) * THR_W'(rpt_rank_reg);
            qsum_reg  <= '0;
            above_reg <= '0;
            run_reg   <= '0;
        end
        proc_idx_reg <= rd_idx_reg[IW-1:0];

        if (proc_valid_reg)
        begin
            if (bin_c != 32'd0)
            begin
                if (!seen_reg)
                begin
                    lo_reg <= proc_idx_reg;
                end
                hi_reg <= proc_idx_reg;
            end
            if (at_off)
            begin
                qsum_reg  <= qsum_next;
                above_reg <= above_next;
                run_reg   <= run_next;
                if (!found_reg && hit)
                begin
                    pct_reg <= rel;
                end
            end
        end

        if (out_load)
        begin
            out_empty_reg <= (total_reg == 32'd0);
            out_lo_reg    <= seen_reg ? 7'(lo_reg) : 7'd0;
            out_hi_reg    <= seen_reg ? 7'(hi_reg) : 7'd0;
            out_total_reg <= total_reg;
            out_qsum_reg  <= qsum_reg;
            out_above_reg <= (above_reg > ABOVE_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : above_reg[31:0];
            out_pct_reg   <= found_reg ? pct_reg : 8'hFF;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_empty_reg;
    assign m_tdata  = {2'b00, out_pct_reg, out_above_reg, 64'(out_qsum_reg), out_total_reg,
                       out_hi_reg, out_lo_reg};

`ifndef NO_ASSERTIONS
    // the add write port and the clearing pass never compete
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !a1_valid_reg)
        else $error("add write during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_REPORT) |=> (state_reg == ST_LOAD))
        else $error("report transfer did not start a load");

    // bin data is only processed while the scan is running
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> (state_reg == ST_SCAN))
        else $error("bin processed outside the scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside the finish step");
`endif

endmodule

### sim/tb_per_position_quality_histogram_top.sv
// self-checking testbench for the per-position quality histogram, with an in-bench predictor
module tb_per_position_quality_histogram_top
    import ppqh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 4_000_000;
    localparam int         SETTLE_CYCLES = QUALITY_LEVELS_DEF + 8;
    localparam int         MAX_PRINTS   = 40;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 186;

    typedef struct packed {
        logic        empty;
        logic [6:0]  lowest;
        logic [6:0]  highest;
        logic [31:0] total;
        logic [63:0] qsum;
        logic [31:0] above;
        logic [7:0]  pct;
    } report_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata   = '0;  // position, quality_char, percent_rank
    logic [1:0]          s_tuser   = '0;  // op
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // lowest_quality, highest_quality, total_count, quality_sum, count_above_offset,
    // percentile_value
    logic [151:0]        m_tdata;
    logic [0:0]          m_tuser;         // empty_res
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    bit [31:0]   bin_tally [POSITIONS_DEF][QUALITY_LEVELS_DEF];
    bit [31:0]   pos_tally [POSITIONS_DEF];
    logic [6:0]  offset_reg = OFFSET_RESET;
    report_t     expected_reports[$];
    report_t     want_report;

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          send_idle_table [4] = '{0, 58, 0, 23};
    int          recv_stall_table[4] = '{0, 0, 58, 23};
    int          hot_pos[4];

    per_position_quality_histogram_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("per_position_quality_histogram_top: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // one report computed over the bins of a position
    function automatic report_t histogram_report(input logic [7:0] pos, input logic [6:0] rank);
        report_t    r;
        bit [31:0]  total;
        bit [31:0]  c;
        bit [63:0]  thresh;
        bit [63:0]  run;
        bit [63:0]  above;
        bit         seen;
        bit         found;
        int         off;
        total  = pos_tally[pos];
        thresh = (64'(total) * 64'(rank)) / 64'(PERCENT_SCALE);
        off    = int'(offset_reg);
        run    = '0;
        above  = '0;
        seen   = 1'b0;
        found  = 1'b0;
        r      = '0;
        r.pct  = 8'hFF;
        for (int i = 0; i < QUALITY_LEVELS_DEF; i++)
        begin
            c = bin_tally[pos][i];
            if (c != 0)
            begin
                if (!seen)
                    r.lowest = 7'(i);
                r.highest = 7'(i);
                seen = 1'b1;
            end
            if (i >= off)
            begin
                r.qsum = r.qsum + 64'(c) * 64'(i - off);
                above  = above + 64'(c);
                run    = run + 64'(c);
                if (!found && run >= thresh)
                begin
                    r.pct = 8'(i - off);
                    found = 1'b1;
                end
            end
        end
        r.above = (above > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : above[31:0];
        r.total = total;
        r.empty = (total == 0);
        return r;
    endfunction

    function automatic void histogram_apply(input logic [1:0] op, input logic [7:0] pos,
                                            input logic [6:0] qc, input logic [6:0] rank);
        case (op)
            OP_ADD:
            begin
                // counters stop at all ones
                if (bin_tally[pos][qc] != 32'hFFFF_FFFF)
                    bin_tally[pos][qc]++;
                if (pos_tally[pos] != 32'hFFFF_FFFF)
                    pos_tally[pos]++;
            end
            OP_REPORT:
                expected_reports.push_back(histogram_report(pos, rank));
            OP_CLEAR:
            begin
                foreach (bin_tally[p, q])
                    bin_tally[p][q] = '0;
                foreach (pos_tally[p])
                    pos_tally[p] = '0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("report with none pending", m_tdata[63:0], 64'd0);
            else
            begin
                want_report = expected_reports.pop_front();
                if (m_tuser[0] !== want_report.empty)
                    report_mismatch("empty_res", 64'(m_tuser[0]), 64'(want_report.empty));
                if (m_tdata[6:0] !== want_report.lowest)
                    report_mismatch("lowest_quality", 64'(m_tdata[6:0]),
                                    64'(want_report.lowest));
                if (m_tdata[13:7] !== want_report.highest)
                    report_mismatch("highest_quality", 64'(m_tdata[13:7]),
                                    64'(want_report.highest));
                if (m_tdata[45:14] !== want_report.total)
                    report_mismatch("total_count", 64'(m_tdata[45:14]),
                                    64'(want_report.total));
                if (m_tdata[109:46] !== want_report.qsum)
                    report_mismatch("quality_sum", m_tdata[109:46], want_report.qsum);
                if (m_tdata[141:110] !== want_report.above)
                    report_mismatch("count_above_offset", 64'(m_tdata[141:110]),
                                    64'(want_report.above));
                if (m_tdata[149:142] !== want_report.pct)
                    report_mismatch("percentile_value", 64'(m_tdata[149:142]),
                                    64'(want_report.pct));
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] pos,
                             input logic [6:0] qc, input logic [6:0] rank);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, rank, qc, pos};
        do @(posedge clk); while (!s_tready);
        histogram_apply(op, pos, qc, rank);
    endtask

    // drop valid, let all reports return, then let a pending add or clear pass finish
    task automatic wait_block_idle();
        @(negedge clk) s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_offset(input logic [6:0] value);
        wait_block_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_QUALITY_OFFSET, 2'b00};
        pwdata  <= {25'd0, value};
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        offset_reg = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {25'd0, value})
            report_mismatch("quality_offset readback", 64'(prdata), 64'(value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_reports();
        send_item(OP_REPORT, 8'd0, 7'd0, 7'd0);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd127);
    endtask

    task automatic test_field_extremes();
        send_item(OP_ADD, 8'd0, 7'd0, 7'd0);
        send_item(OP_ADD, 8'd255, 7'd127, 7'd127);
        send_item(OP_ADD, 8'd255, 7'd33, 7'd0);
        send_item(OP_ADD, 8'd255, 7'd32, 7'd0);
        send_item(OP_ADD, 8'd170, 7'd85, 7'd85);
        send_item(OP_ADD, 8'd85, 7'd42, 7'd42);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd100);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd50);
        send_item(OP_REPORT, 8'd255, 7'd127, 7'd0);
        send_item(OP_REPORT, 8'd0, 7'd0, 7'd127);
        send_item(OP_REPORT, 8'd170, 7'd0, 7'd100);
    endtask

    task automatic test_offset_extremes();
        write_offset(7'd0);
        send_item(OP_REPORT, 8'd0, 7'd0, 7'd100);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd67);
        write_offset(7'd127);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd100);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd1);
        // nothing stored at or above the offset here
        send_item(OP_REPORT, 8'd170, 7'd0, 7'd127);
    endtask

    task automatic test_unused_op();
        send_item(OP_UNUSED, 8'd255, 7'd127, 7'd127);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd100);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 8'd0, 7'd0, 7'd0);
        send_item(OP_REPORT, 8'd255, 7'd0, 7'd100);
        send_item(OP_REPORT, 8'd0, 7'd0, 7'd0);
    endtask

    function automatic logic [6:0] pick_quality();
        int q;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            q = int'(offset_reg) + int'($urandom_range(0, 41));
        else if (sel < 85)
            q = int'(offset_reg) - int'($urandom_range(1, 8));
        else
            q = int'($urandom_range(0, 127));
        if (q > 127)
            q = 127;
        if (q < 0)
            q = 0;
        return 7'(q);
    endfunction

    task automatic test_random_traffic(input int phase, input logic [6:0] offset, input int items);
        int         counted;
        int         sel;
        bit         drained;
        logic [7:0] pos;
        logic [6:0] rank;
        write_offset(offset);
        send_idle_pct  = send_idle_table[phase % 4];
        recv_stall_pct = recv_stall_table[phase % 4];
        foreach (hot_pos[h])
            hot_pos[h] = $urandom_range(0, 255);
        counted = 0;
        drained = 1'b0;
        while (counted < items)
        begin
            if (!drained && counted == items / 2)
            begin
                wait_block_idle();
                drained = 1'b1;
            end
            sel = $urandom_range(0, 999);
            // mostly traffic on a few positions so histograms fill up
            if ($urandom_range(0, 99) < 85)
                pos = 8'(hot_pos[$urandom_range(0, 3)]);
            else
                pos = 8'($urandom_range(0, 255));
            if (sel < 3)
            begin
                send_item(OP_CLEAR, 8'($urandom), 7'($urandom), 7'($urandom));
                counted++;
            end
            else if (sel < 25)
                send_item(OP_UNUSED, 8'($urandom), 7'($urandom), 7'($urandom));
            else if (sel < 160)
            begin
                if ($urandom_range(0, 99) < 85)
                    rank = 7'($urandom_range(0, 100));
                else
                    rank = 7'($urandom_range(101, 127));
                send_item(OP_REPORT, pos, 7'($urandom), rank);
                counted++;
            end
            else
            begin
                send_item(OP_ADD, pos, pick_quality(), 7'($urandom));
                counted++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        test_empty_reports();
        test_field_extremes();
        test_offset_extremes();
        test_unused_op();
        test_clear();
        test_random_traffic(0, 7'd33, PHASE_ITEMS);
        test_random_traffic(1, 7'd0, PHASE_ITEMS);
        test_random_traffic(2, 7'd127, PHASE_ITEMS);
        test_random_traffic(3, 7'd64, PHASE_ITEMS);
        test_random_traffic(4, 7'($urandom_range(0, 127)), PHASE_ITEMS);
        test_random_traffic(5, 7'd33, PHASE_ITEMS);
        test_random_traffic(6, 7'($urandom_range(0, 127)), PHASE_ITEMS);
        test_random_traffic(PHASES - 1, 7'd1, PHASE_ITEMS);
        wait_block_idle();
        if (mismatch_count == 0)
            $display("per_position_quality_histogram_top: match");
        else
            $display("per_position_quality_histogram_top: mismatch");
        $finish;
    end

endmodule
